@@ src/pglb_pkg.sv @@
// Package for the palette gamma LUT blend unit: constants, register codes, payload types.
package pglb_pkg;

  // Default number of gamma rows per table set
  localparam int unsigned GammaLevelsDef = 19;
  // Palettes that carry a class in the class map
  localparam int unsigned NumPalettes    = 32;

  // Color channels and channel width
  localparam int unsigned NumCh = 3;
  localparam int unsigned ChW   = 5;

  // Register port geometry (64-bit class map puts registers on 8-byte steps)
  localparam int unsigned PaddrW = 6;
  localparam int unsigned PdataW = 64;

  // Special values
  localparam logic [15:0] KeyColor      = 16'h2D9F;
  localparam logic [4:0]  HighPalStart  = 5'h1B;
  localparam logic [4:0]  KeyPalLow     = 5'd16;
  localparam logic [4:0]  CoeffMax      = 5'd16;
  localparam logic [4:0]  GammaLevelRst = 5'd3;

  // Class codes
  localparam logic [1:0] ClassPass = 2'd0;
  localparam logic [1:0] ClassSet1 = 2'd2;

  // Request type codes
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqColor = 1'b1;

  // Register index (byte address / 8)
  typedef enum logic [2:0] {
    REG_GAMMA_LEVEL  = 3'd0,
    REG_BLEND_ENABLE = 3'd1,
    REG_BLEND_COEFF  = 3'd2,
    REG_FADE_COLOR   = 3'd3,
    REG_CLASS_MAP    = 3'd4,
    REG_ALT_PALETTE  = 3'd5
  } pglb_reg_e;

  // Input request
  typedef struct packed {
    logic        req_type;
    logic        table_set;
    logic [4:0]  table_row;
    logic [4:0]  table_col;
    logic [4:0]  table_value;
    logic [4:0]  palette;
    logic [15:0] color;
  } pglb_req_t;

  // Output result
  typedef struct packed {
    logic [14:0] out_color;
    logic        write_flag;
  } pglb_rsp_t;

  // Configuration register contents
  typedef struct packed {
    logic [4:0]  gamma_level;
    logic        blend_enable;
    logic [4:0]  blend_coeff;
    logic [14:0] fade_color;
    logic [63:0] class_map;
    logic [3:0]  alt_palette;
  } pglb_cfg_t;

  // Decoded color request held while the table read is in flight
  typedef struct packed {
    logic        lookup;
    logic        key;
    logic [14:0] color;
  } pglb_info_t;

endpackage

@@ src/palette_gamma_lut_blend_unit.sv @@
// Top level of the palette gamma LUT blend unit: decode, gamma table RAMs, pipeline.
//
//   port group     dir   handshake                 payload
//   in_*           in    in_valid_i / in_ready_o   in_req_i  (pglb_req_t)
//   out_*          out   out_valid_o / out_ready_i out_rsp_o (pglb_rsp_t)
//   APB            in    psel & penable & pwrite   paddr, pwdata -> prdata
//
// One request per cycle while in_ready_o is high; a color result passes the table RAM read
// register and then the blend into the output register.
// Each channel has its own copy of the gamma tables, so the three lookups run in parallel.
// Loads write all three copies at acceptance and give no result.
// Reset initializes registers only; table contents are undefined until loaded.
// A stalled output holds stage 1 and the RAM read data; in_ready_o drops once stage 1
// is also full.
module palette_gamma_lut_blend_unit
  import pglb_pkg::*;
#(
  parameter int unsigned GammaLevels = GammaLevelsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pglb_req_t         in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pglb_rsp_t         out_rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned RamDepth = 2 * GammaLevels * 32;
  localparam int unsigned AddrW    = $clog2(RamDepth);

  pglb_cfg_t                 cfg;
  logic                      adv;
  logic                      s1_valid_q;
  pglb_info_t                s1_info_q, info_d;
  logic [NumCh-1:0][ChW-1:0] ram_rdata;
  logic [AddrW-1:0]          raddr [NumCh];
  logic [AddrW-1:0]          waddr;
  logic [AddrW-1:0]          rd_base;
  logic [1:0]                cls;
  logic                      pal_ok;
  logic [4:0]                rd_row;
  logic                      rd_set;
  logic                      accept;
  logic                      color_acc;
  logic                      load_we;

  // Registers
  pglb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake
  assign in_ready_o = ~s1_valid_q | adv;
  assign accept     = in_valid_i & in_ready_o;
  assign color_acc  = accept & (in_req_i.req_type == ReqColor);

  // Color decode
  assign pal_ok = {1'b0, in_req_i.palette} < 6'(NumPalettes);
  assign cls    = pal_ok ? cfg.class_map[{in_req_i.palette, 1'b0} +: 2] : ClassPass;

  always_comb begin
    info_d.lookup = (cls != ClassPass) && (cfg.gamma_level != '0);
    info_d.key    = ~cfg.blend_enable & info_d.lookup
                  & ((in_req_i.palette == KeyPalLow) || (in_req_i.palette > HighPalStart))
                  & (in_req_i.color == KeyColor);
    info_d.color  = in_req_i.color[14:0];
  end

  // Row saturates to the last one; set 1 for class 2, or for the alternate palette when blending is off
  assign rd_row = ({1'b0, cfg.gamma_level} > 6'(GammaLevels)) ? 5'(GammaLevels - 1)
                                                               : cfg.gamma_level - 5'd1;
  assign rd_set = (cls == ClassSet1)
                | (~cfg.blend_enable & (in_req_i.palette == {1'b1, cfg.alt_palette}));
  assign rd_base = rd_set ? AddrW'(GammaLevels * 32) : '0;

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      raddr[i] = rd_base + AddrW'({rd_row, in_req_i.color[i*ChW +: ChW]});
    end
  end

  // Loads write at acceptance; a later color read sees them, an earlier one already read
  assign load_we = accept & (in_req_i.req_type == ReqLoad)
                 & ({1'b0, in_req_i.table_row} < 6'(GammaLevels));
  assign waddr   = (in_req_i.table_set ? AddrW'(GammaLevels * 32) : AddrW'(0))
                 + AddrW'({in_req_i.table_row, in_req_i.table_col});

  // One table copy per channel
  for (genvar g = 0; g < NumCh; g++) begin : g_ch
    pglb_ram #(
      .Width (ChW),
      .Depth (RamDepth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (load_we),
      .waddr_i (waddr),
      .wdata_i (in_req_i.table_value),
      .re_i    (color_acc),
      .raddr_i (raddr[g]),
      .rdata_o (ram_rdata[g])
    );
  end

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= color_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (color_acc) begin
      s1_info_q <= info_d;
    end
  end

  // Blend and output register
  pglb_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid_q),
    .s1_info_i   (s1_info_q),
    .ram_rdata_i (ram_rdata),
    .cfg_i       (cfg),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

`ifndef SYNTHESIS
  // Accepted color request lands in stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni) color_acc |=> s1_valid_q)
    else $error("color request lost before stage 1");

  // Stalled stage 1 keeps its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> (s1_valid_q && $stable(s1_info_q)))
    else $error("stage 1 changed while stalled");

  // Suppressed result carries a zero color
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_rsp_o.write_flag) |-> (out_rsp_o.out_color == '0))
    else $error("key result with nonzero color");
`endif

endmodule

@@ src/pglb_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module pglb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/pglb_cfg.sv @@
// APB register file for the palette gamma LUT blend unit.
module pglb_cfg
  import pglb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output pglb_cfg_t         cfg_o
);

  pglb_cfg_t cfg_q, cfg_d;
  pglb_reg_e reg_idx;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_idx = pglb_reg_e'(paddr[PaddrW-1:3]);
  assign wr_en   = psel & penable & pwrite;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_GAMMA_LEVEL:  cfg_d.gamma_level  = pwdata[4:0];
        REG_BLEND_ENABLE: cfg_d.blend_enable = pwdata[0];
        REG_BLEND_COEFF:  cfg_d.blend_coeff  = pwdata[4:0];
        REG_FADE_COLOR:   cfg_d.fade_color   = pwdata[14:0];
        REG_CLASS_MAP:    cfg_d.class_map    = pwdata;
        REG_ALT_PALETTE:  cfg_d.alt_palette  = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gamma_level  <= GammaLevelRst;
      cfg_q.blend_enable <= 1'b0;
      cfg_q.blend_coeff  <= '0;
      cfg_q.fade_color   <= '0;
      cfg_q.class_map    <= '0;
      cfg_q.alt_palette  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_GAMMA_LEVEL:  prdata = PdataW'(cfg_q.gamma_level);
      REG_BLEND_ENABLE: prdata = PdataW'(cfg_q.blend_enable);
      REG_BLEND_COEFF:  prdata = PdataW'(cfg_q.blend_coeff);
      REG_FADE_COLOR:   prdata = PdataW'(cfg_q.fade_color);
      REG_CLASS_MAP:    prdata = cfg_q.class_map;
      REG_ALT_PALETTE:  prdata = PdataW'(cfg_q.alt_palette);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/pglb_blend.sv @@
// Back stage: picks looked-up or raw channels, blends toward the fade color, output register.
module pglb_blend
  import pglb_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s1_valid_i,
  input  pglb_info_t                s1_info_i,
  input  logic [NumCh-1:0][ChW-1:0] ram_rdata_i,
  input  pglb_cfg_t                 cfg_i,
  output logic                      adv_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output pglb_rsp_t                 out_rsp_o
);

  logic                      out_valid_q;
  pglb_rsp_t                 rsp_q, rsp_d;
  logic [4:0]                coeff;
  logic [NumCh-1:0][ChW-1:0] ch_sel;
  logic [NumCh-1:0][ChW-1:0] ch_out;
  logic signed [5:0]         diff  [NumCh];
  logic signed [11:0]        prod  [NumCh];
  logic signed [11:0]        step  [NumCh];

  // Output register frees when empty or taken
  assign adv_o = ~out_valid_q | out_ready_i;

  assign coeff = (cfg_i.blend_coeff > CoeffMax) ? CoeffMax : cfg_i.blend_coeff;

  // Per-channel select and blend: ch + floor((fade - ch) * coeff / 16)
  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      ch_sel[i] = s1_info_i.lookup ? ram_rdata_i[i] : s1_info_i.color[i*ChW +: ChW];
      diff[i]   = $signed({1'b0, cfg_i.fade_color[i*ChW +: ChW]}) - $signed({1'b0, ch_sel[i]});
      prod[i]   = diff[i] * $signed({1'b0, coeff});
      step[i]   = prod[i] >>> 4;
      ch_out[i] = cfg_i.blend_enable ? (ch_sel[i] + step[i][ChW-1:0]) : ch_sel[i];
    end
  end

  // Key color suppresses the write
  always_comb begin
    if (s1_info_i.key) begin
      rsp_d.out_color  = '0;
      rsp_d.write_flag = 1'b0;
    end else begin
      rsp_d.out_color  = {ch_out[2], ch_out[1], ch_out[0]};
      rsp_d.write_flag = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && s1_valid_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

@@ tb/palette_gamma_lut_blend_unit_checker.sv @@
// Scoreboard for the palette gamma LUT blend unit: snoops config, grades colors, compares.
`timescale 1ns / 100ps

module palette_gamma_lut_blend_unit_checker
  import pglb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  pglb_req_t         in_req_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  pglb_rsp_t         out_rsp_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [PaddrW-1:0] paddr_i,
  input  logic [PdataW-1:0] pwdata_i,
  output int unsigned       mismatch_cnt_o,
  output int unsigned       pending_o
);

  // Shadow of the register file and of the gamma tables
  pglb_cfg_t      cfg;
  logic [ChW-1:0] gamma_mem [2][GammaLevelsDef][32];
  pglb_rsp_t      graded_q [$];

  // Expected result of one color request under the current settings
  function automatic pglb_rsp_t grade_color(pglb_req_t r);
    pglb_rsp_t      rsp;
    logic [1:0]     cls;
    logic [ChW-1:0] ch [NumCh];
    logic [ChW-1:0] fade_ch;
    logic [4:0]     row;
    logic [4:0]     coeff;
    logic           set1;
    int             step;
    int             i;
    cls = cfg.class_map[2*r.palette +: 2];
    rsp.write_flag = 1'b1;
    for (i = 0; i < NumCh; i++) ch[i] = r.color[ChW*i +: ChW];

    // Table lookup: skipped for pass-through class and for level zero
    if (cls != ClassPass && cfg.gamma_level != 5'd0) begin
      row = (cfg.gamma_level > GammaLevelsDef) ? 5'(GammaLevelsDef - 1) : cfg.gamma_level - 5'd1;
      if (cfg.blend_enable) begin
        set1 = (cls == ClassSet1);
      end else begin
        set1 = (cls == ClassSet1) || (r.palette == {1'b1, cfg.alt_palette});
      end
      // key color leaves the faded entry alone
      if (!cfg.blend_enable && (r.palette == KeyPalLow || r.palette > HighPalStart) &&
          r.color == KeyColor) begin
        rsp.out_color  = '0;
        rsp.write_flag = 1'b0;
        return rsp;
      end
      for (i = 0; i < NumCh; i++) ch[i] = gamma_mem[set1][row][ch[i]];
    end

    // Blend toward the fade color, step rounded toward minus infinity
    if (cfg.blend_enable) begin
      coeff = (cfg.blend_coeff > CoeffMax) ? CoeffMax : cfg.blend_coeff;
      for (i = 0; i < NumCh; i++) begin
        fade_ch = cfg.fade_color[ChW*i +: ChW];
        step    = ((int'(fade_ch) - int'(ch[i])) * int'(coeff)) >>> 4;
        ch[i]   = ChW'(int'(ch[i]) + step);
      end
    end
    rsp.out_color = {ch[2], ch[1], ch[0]};
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pglb_rsp_t want;
    if (!rst_ni) begin
      cfg             = '0;
      cfg.gamma_level = GammaLevelRst;
      graded_q.delete();
      mismatch_cnt_o  = 0;
      pending_o       = 0;
    end else begin
      // Register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (pglb_reg_e'(paddr_i[PaddrW-1:3]))
          REG_GAMMA_LEVEL:  cfg.gamma_level  = pwdata_i[4:0];
          REG_BLEND_ENABLE: cfg.blend_enable = pwdata_i[0];
          REG_BLEND_COEFF:  cfg.blend_coeff  = pwdata_i[4:0];
          REG_FADE_COLOR:   cfg.fade_color   = pwdata_i[14:0];
          REG_CLASS_MAP:    cfg.class_map    = pwdata_i[63:0];
          REG_ALT_PALETTE:  cfg.alt_palette  = pwdata_i[3:0];
          default: ;
        endcase
      end

      // Results against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (graded_q.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, got color %h flag %b",
                   $time, out_rsp_i.out_color, out_rsp_i.write_flag);
          mismatch_cnt_o++;
        end else begin
          want = graded_q.pop_front();
          if (out_rsp_i.out_color !== want.out_color) begin
            $display("%0t: out_color mismatch: expected %h, got %h",
                     $time, want.out_color, out_rsp_i.out_color);
            mismatch_cnt_o++;
          end
          if (out_rsp_i.write_flag !== want.write_flag) begin
            $display("%0t: write_flag mismatch: expected %b, got %b",
                     $time, want.write_flag, out_rsp_i.write_flag);
            mismatch_cnt_o++;
          end
        end
      end

      // Accepted request: table load or color to grade
      if (in_valid_i && in_ready_i) begin
        if (in_req_i.req_type == ReqLoad) begin
          if (in_req_i.table_row < GammaLevelsDef) begin
            gamma_mem[in_req_i.table_set][in_req_i.table_row][in_req_i.table_col] =
              in_req_i.table_value;
          end
        end else begin
          graded_q.push_back(grade_color(in_req_i));
        end
      end
      pending_o = graded_q.size();
    end
  end

endmodule

@@ tb/palette_gamma_lut_blend_unit_tb.sv @@
// Testbench top for the palette gamma LUT blend unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module palette_gamma_lut_blend_unit_tb;
  import pglb_pkg::*;

  localparam int NumPhases     = 12;
  localparam int ItemsPerPhase = 52;
  localparam int PipeSettle    = 4;
  localparam int QuietLimit    = 2000;
  // Table rows that get filled: 0 .. FillLow-1 and FillHigh .. last
  localparam int FillLow       = 4;
  localparam int FillHigh      = 15;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  pglb_req_t         in_req_i;
  logic              out_valid_o;
  logic              out_ready_i;
  pglb_rsp_t         out_rsp_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  int unsigned mismatch_cnt;
  int unsigned pending;
  int unsigned quiet_cycles;
  logic        steady;
  logic [3:0]  alt_pal;

  palette_gamma_lut_blend_unit u_top (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_req_i,
    .out_valid_o, .out_ready_i, .out_rsp_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  palette_gamma_lut_blend_unit_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_req_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_rsp_i(out_rsp_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .mismatch_cnt_o(mismatch_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: too long without any accepted transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result sink with random back-pressure
  initial begin : rsp_sink
    int stall;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Random filler for the fields a request does not use
  function automatic pglb_req_t noise_req();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(pglb_req_t)-1:0];
  endfunction

  function automatic pglb_req_t mk_load(logic s, logic [4:0] row, logic [4:0] col,
                                        logic [4:0] val);
    pglb_req_t r;
    r             = noise_req();
    r.req_type    = ReqLoad;
    r.table_set   = s;
    r.table_row   = row;
    r.table_col   = col;
    r.table_value = val;
    return r;
  endfunction

  function automatic pglb_req_t mk_color(logic [4:0] pal, logic [15:0] color);
    pglb_req_t r;
    r          = noise_req();
    r.req_type = ReqColor;
    r.palette  = pal;
    r.color    = color;
    return r;
  endfunction

  // Color mix: key color, near-key, channel extremes, plain random
  function automatic logic [15:0] pick_color();
    case ($urandom_range(0, 9))
      0: return KeyColor;
      1: return KeyColor | 16'h8000;
      2: return {($urandom_range(0, 1) != 0) ? 1'b1 : 1'b0,
                 ($urandom_range(0, 1) != 0) ? 5'd31 : 5'd0,
                 ($urandom_range(0, 1) != 0) ? 5'd31 : 5'd0,
                 ($urandom_range(0, 1) != 0) ? 5'd31 : 5'd0};
      default: return 16'($urandom);
    endcase
  endfunction

  // Level whose lookup row is filled: zero, past the end, or a filled row
  function automatic logic [4:0] pick_level();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(20, 31));
      default: return ($urandom_range(0, 1) != 0) ? 5'($urandom_range(1, FillLow))
                                                  : 5'($urandom_range(FillHigh + 1,
                                                                      GammaLevelsDef));
    endcase
  endfunction

  // One request; valid stays up across back-to-back requests
  task automatic push_req(input pglb_req_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Hold requests until every result is back and loads have settled
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
    repeat (PipeSettle) @(posedge clk_i);
  endtask

  task automatic apb_write(input pglb_reg_e idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic set_regs(input logic [4:0] lvl, input logic bl, input logic [4:0] cf,
                          input logic [14:0] fd, input logic [63:0] cm, input logic [3:0] ap);
    apb_write(REG_GAMMA_LEVEL, 64'(lvl));
    apb_write(REG_BLEND_ENABLE, 64'(bl));
    apb_write(REG_BLEND_COEFF, 64'(cf));
    apb_write(REG_FADE_COLOR, 64'(fd));
    apb_write(REG_CLASS_MAP, cm);
    apb_write(REG_ALT_PALETTE, 64'(ap));
    psel    <= 1'b0;
    penable <= 1'b0;
    alt_pal = ap;
  endtask

  initial begin : stim
    int          ph;
    int          n;
    int          s;
    int          row;
    int          col;
    logic [15:0] color;
    logic [4:0]  pal;
    logic [4:0]  lvl;
    logic        bl;
    logic [4:0]  cf;
    logic [14:0] fd;
    logic [63:0] cm;
    logic [3:0]  ap;

    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_req_i   <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    steady     = 1'b1;
    alt_pal    = 4'd0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the low and high rows; every level used below looks up only these
    for (s = 0; s < 2; s++) begin
      for (row = 0; row < GammaLevelsDef; row++) begin
        if (row < FillLow || row >= FillHigh) begin
          for (col = 0; col < 32; col++) begin
            push_req(mk_load(1'(s), 5'(row), 5'(col), 5'($urandom_range(0, 31))));
          end
        end
      end
    end

    // Directed: classes 0..3 on palettes 0..3, palette 5 on set 1, rest set 0
    steady = 1'b0;
    drain();
    set_regs(5'd19, 1'b0, 5'd0, 15'd0, 64'h5555_5555_5555_59E4, 4'd4);
    push_req(mk_load(1'b0, 5'd0, 5'd0, 5'd31));
    push_req(mk_load(1'b1, 5'd18, 5'd31, 5'd0));
    push_req(mk_load(1'b0, 5'd19, 5'd5, 5'd7));    // row past the table: ignored
    push_req(mk_load(1'b1, 5'd31, 5'd31, 5'd31));  // ignored as well
    push_req(mk_color(5'd16, KeyColor));            // key palettes drop the key color
    push_req(mk_color(5'd31, KeyColor));
    push_req(mk_color(5'd28, KeyColor));
    push_req(mk_color(5'd27, KeyColor));            // just below the high key range
    push_req(mk_color(5'd16, KeyColor | 16'h8000)); // top bit breaks the key match
    push_req(mk_color(5'd0, KeyColor));             // pass class
    push_req(mk_color(5'd2, 16'h7FFF));             // set 1 class
    push_req(mk_color(5'd3, 16'h0000));             // class three behaves as set 0
    push_req(mk_color(5'd20, 16'h4210));            // alt palette goes to set 1
    push_req(mk_color(5'd1, 16'hFFFF));
    push_req(mk_color(5'd5, 16'h8000));

    // Blending, coefficient above full scale
    drain();
    set_regs(5'd19, 1'b1, 5'd17, 15'h7FFF, 64'h5555_5555_5555_59E4, 4'd4);
    push_req(mk_color(5'd16, KeyColor));
    push_req(mk_color(5'd0, 16'h0000));
    push_req(mk_color(5'd2, 16'h7FFF));
    push_req(mk_color(5'd20, 16'h1CE7));

    // Level zero skips the lookup and the key rule
    drain();
    set_regs(5'd0, 1'b0, 5'd8, 15'h0000, 64'h5555_5555_5555_59E4, 4'd4);
    push_req(mk_color(5'd16, KeyColor));
    push_req(mk_color(5'd1, 16'h1234));

    // Level past the last row saturates
    drain();
    set_regs(5'd31, 1'b0, 5'd0, 15'h0000, 64'h5555_5555_5555_59E4, 4'd4);
    push_req(mk_color(5'd1, 16'h5A5A));
    push_req(mk_color(5'd31, KeyColor));

    // Random phases, each under its own settings
    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          lvl = 5'd1;  bl = 1'b0; cf = 5'd0;  fd = 15'h0000; cm = '1; ap = 4'd0;
        end
        1: begin
          lvl = 5'd19; bl = 1'b1; cf = 5'd16; fd = 15'h7FFF; cm = {32{2'b10}}; ap = 4'd15;
        end
        2: begin
          lvl = 5'd0;  bl = 1'b1; cf = 5'd31; fd = 15'h1234; cm = {32{2'b01}}; ap = 4'd8;
        end
        3: begin
          lvl = 5'd31; bl = 1'b0; cf = 5'd0;  fd = 15'h7FFF; cm = {$urandom, $urandom};
          ap = 4'd12;
        end
        default: begin
          lvl = pick_level();
          bl  = 1'($urandom_range(0, 1));
          cf  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                            : 5'($urandom_range(0, 16));
          fd  = 15'($urandom);
          cm  = {$urandom, $urandom};
          ap  = 4'($urandom_range(0, 15));
        end
      endcase
      drain();
      set_regs(lvl, bl, cf, fd, cm, ap);
      steady = (ph % 3 == 2);

      for (n = 0; n < ItemsPerPhase; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          // table rewrite, now and then out of range
          push_req(mk_load(1'($urandom_range(0, 1)),
                           ($urandom_range(0, 9) == 0) ? 5'($urandom_range(19, 31))
                                                       : 5'($urandom_range(0, 18)),
                           5'($urandom_range(0, 31)), 5'($urandom_range(0, 31))));
        end else begin
          color = pick_color();
          pal   = 5'($urandom_range(0, 31));
          if (color == KeyColor && $urandom_range(0, 1) != 0) begin
            pal = ($urandom_range(0, 4) == 0) ? KeyPalLow : 5'($urandom_range(28, 31));
          end else if ($urandom_range(0, 7) == 0) begin
            pal = {1'b1, alt_pal};
          end
          push_req(mk_color(pal, color));
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ palette_gamma_lut_blend_unit.f @@
src/pglb_pkg.sv
src/pglb_ram.sv
src/pglb_cfg.sv
src/pglb_blend.sv
src/palette_gamma_lut_blend_unit.sv
tb/palette_gamma_lut_blend_unit_checker.sv
tb/palette_gamma_lut_blend_unit_tb.sv
